### hdl/arst_pkg.sv
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types and codes of the request slot tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package arst_pkg;

  localparam int SelW      = 6;
  localparam int ThreadW   = 16;
  localparam int IdW       = 32;
  localparam int TickW     = 64;
  localparam int EndpointW = 32;
  localparam int PrioW     = 32;

  // operation codes
  localparam logic [1:0] FuncCreate   = 2'd0;
  localparam logic [1:0] FuncComplete = 2'd1;
  localparam logic [1:0] FuncCancel   = 2'd2;
  localparam logic [1:0] FuncTimeout  = 2'd3;

  // result codes
  localparam logic [1:0] ResOk         = 2'd0;
  localparam logic [1:0] ResNoThread   = 2'd1;
  localparam logic [1:0] ResFull       = 2'd2;
  localparam logic [1:0] ResNotPending = 2'd3;

  // slot status codes
  localparam logic [1:0] StPending   = 2'd0;
  localparam logic [1:0] StCompleted = 2'd1;
  localparam logic [1:0] StCancelled = 2'd2;
  localparam logic [1:0] StTimedOut  = 2'd3;

  typedef struct packed {
    logic                 busy;
    logic [1:0]           status;
    logic [IdW-1:0]       id;
    logic [ThreadW-1:0]   waiter;
    logic [TickW-1:0]     deadline;
    logic [EndpointW-1:0] endpoint;
    logic [PrioW-1:0]     prio;
    logic                 determ;
  } slot_rec_t;

  // free list control
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fl_ctrl_t;

  // slot table control
  typedef struct packed {
    logic rd;
    logic wr;
  } st_ctrl_t;

endpackage : arst_pkg

`default_nettype wire

### hdl/arst_free_list.sv
// ----------------------------------------------------------------------------
// arst_free_list
// LIFO free list of slots: head register, link memory and an allocation
// watermark that stands in for the initial contents of the link memory.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_free_list #(
  parameter int SLOT_COUNT = 64,
  parameter int IdxW       = $clog2(SLOT_COUNT)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  arst_pkg::fl_ctrl_t    ctrl_i,
  input  wire  [IdxW-1:0]       push_idx_i,
  output logic [IdxW:0]         head_o,
  output logic [IdxW:0]         mark_o
);
  import arst_pkg::*;

  // a link may hold SLOT_COUNT, the end-of-list mark
  logic [IdxW:0]   link_mem [SLOT_COUNT];
  logic [IdxW:0]   link_rdata_q;
  logic [IdxW:0]   head_q, head_d;
  logic [IdxW:0]   mark_q, mark_d;
  logic            fresh;
  logic [IdxW:0]   next_head;

  // Slots at or above the watermark were never popped, so their link was never
  // written and is taken as the next index.
  assign fresh     = (head_q == mark_q);
  assign next_head = fresh ? (head_q + (IdxW+1)'(1)) : link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      link_mem[push_idx_i] <= head_q;
    end
    if (ctrl_i.rd && (head_q < (IdxW+1)'(SLOT_COUNT))) begin
      link_rdata_q <= link_mem[head_q[IdxW-1:0]];
    end
  end

  always_comb begin
    head_d = head_q;
    mark_d = mark_q;
    if (ctrl_i.pop) begin
      head_d = next_head;
      if (fresh) begin
        mark_d = mark_q + (IdxW+1)'(1);
      end
    end else if (ctrl_i.push) begin
      head_d = {1'b0, push_idx_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      mark_q <= '0;
    end else begin
      head_q <= head_d;
      mark_q <= mark_d;
    end
  end

  assign head_o = head_q;
  assign mark_o = mark_q;

endmodule : arst_free_list

`default_nettype wire

### hdl/arst_slot_table.sv
// ----------------------------------------------------------------------------
// arst_slot_table
// Per-slot request records in one synchronous memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_slot_table #(
  parameter int SLOT_COUNT = 64,
  parameter int IdxW       = $clog2(SLOT_COUNT)
) (
  input  wire                   clk_i,
  input  arst_pkg::st_ctrl_t    ctrl_i,
  input  wire  [IdxW-1:0]       rd_idx_i,
  input  wire  [IdxW-1:0]       wr_idx_i,
  input  arst_pkg::slot_rec_t   wr_rec_i,
  output arst_pkg::slot_rec_t   rd_rec_o
);
  import arst_pkg::*;

  slot_rec_t rec_mem [SLOT_COUNT];
  slot_rec_t rd_rec_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      rec_mem[wr_idx_i] <= wr_rec_i;
    end
    if (ctrl_i.rd) begin
      rd_rec_q <= rec_mem[rd_idx_i];
    end
  end

  assign rd_rec_o = rd_rec_q;

endmodule : arst_slot_table

`default_nettype wire

### hdl/async_request_slot_tracker.sv
// ----------------------------------------------------------------------------
// async_request_slot_tracker
// Tracks outstanding requests in a table of slots linked by a LIFO free list.
// ----------------------------------------------------------------------------
// Result path: the transaction is captured when accepted, and its result is
// registered once it is processed, which waits while a previous result is stalled.
// One transaction at a time: the free list link at the head and the slot
// record are read in the accept cycle and written back when the result is
// registered, and the next transaction waits for that write-back.
// Reset: free list, watermark, id counter and handshake state clear at once;
// there is no clearing pass, the memories need none.
`default_nettype none

module async_request_slot_tracker #(
  parameter int SLOT_COUNT = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  func_i,
  input  wire  [5:0]  slot_sel_i,
  input  wire  [15:0] thread_ref_i,
  input  wire  [31:0] endpoint_ref_i,
  input  wire  [63:0] timeout_ms_i,
  input  wire  [31:0] qos_priority_i,
  input  wire         deterministic_i,
  input  wire  [63:0] now_ticks_i,
  input  wire         waiter_blocked_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  result_code_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] request_id_o,
  output logic [63:0] deadline_o,
  output logic [1:0]  final_status_o,
  output logic        wake_o,
  output logic [15:0] wake_thread_o,
  output logic [31:0] wake_priority_o
);
  import arst_pkg::*;

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CmpW = (IdxW + 1 > SelW) ? IdxW + 1 : SelW;

  // handshake and control
  logic       stage_q, stage_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, done;
  logic [31:0] id_cnt_q, id_cnt_d;

  // captured transaction
  logic [1:0]  func_q;
  logic [5:0]  sel_q;
  logic [15:0] thread_q;
  logic [31:0] endpoint_q;
  logic [63:0] timeout_q;
  logic [31:0] prio_q;
  logic        det_q;
  logic [63:0] now_q;
  logic        blocked_q;

  // result registers
  logic [1:0]  code_q, code_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] rid_q, rid_d;
  logic [63:0] dl_q, dl_d;
  logic [1:0]  fst_q, fst_d;
  logic        wake_q, wake_d;
  logic [15:0] wthr_q, wthr_d;
  logic [31:0] wpri_q, wpri_d;

  fl_ctrl_t    fl_ctrl;
  st_ctrl_t    st_ctrl;
  logic [IdxW:0]   head, mark;
  logic [IdxW-1:0] st_wr_idx;
  slot_rec_t   wr_rec, rd_rec;

  logic [CmpW-1:0] sel_in_cmp, sel_q_cmp;
  logic            sel_in_ok;
  logic            sel_q_ok, slot_pending, wk;
  logic [1:0]      new_status;
  logic [63:0]     dl_new;

  assign accept = in_valid_i && !stage_q;
  assign done   = stage_q && (!out_valid_q || !out_stall_i);

  assign sel_in_cmp = CmpW'(slot_sel_i);
  assign sel_in_ok  = sel_in_cmp < CmpW'(SLOT_COUNT);
  assign sel_q_cmp  = CmpW'(sel_q);
  assign sel_q_ok   = sel_q_cmp < CmpW'(SLOT_COUNT);
  // entries at or above the watermark were never allocated and hence not busy
  assign slot_pending = sel_q_ok && (sel_q_cmp < CmpW'(mark)) && rd_rec.busy
                        && (rd_rec.status == StPending);
  assign wk     = (rd_rec.waiter != '0) && blocked_q;
  assign dl_new = (timeout_q == '0) ? '0 : (now_q + timeout_q);

  always_comb begin
    case (func_q)
      FuncComplete: new_status = StCompleted;
      FuncCancel:   new_status = StCancelled;
      default:      new_status = StTimedOut;
    endcase
  end

  always_comb begin
    fl_ctrl   = '0;
    st_ctrl   = '0;
    fl_ctrl.rd = accept;
    st_ctrl.rd = accept && sel_in_ok;
    st_wr_idx = head[IdxW-1:0];
    wr_rec    = rd_rec;
    id_cnt_d  = id_cnt_q;
    code_d    = code_q;
    idx_d     = idx_q;
    rid_d     = rid_q;
    dl_d      = dl_q;
    fst_d     = fst_q;
    wake_d    = wake_q;
    wthr_d    = wthr_q;
    wpri_d    = wpri_q;
    if (done) begin
      code_d = ResOk;
      idx_d  = '0;
      rid_d  = '0;
      dl_d   = '0;
      fst_d  = StPending;
      wake_d = 1'b0;
      wthr_d = '0;
      wpri_d = '0;
      if (func_q == FuncCreate) begin
        if (thread_q == '0) begin
          code_d = ResNoThread;
        end else if (head == (IdxW+1)'(SLOT_COUNT)) begin
          code_d = ResFull;
        end else begin
          fl_ctrl.pop     = 1'b1;
          st_ctrl.wr      = 1'b1;
          wr_rec.busy     = 1'b1;
          wr_rec.status   = StPending;
          wr_rec.id       = id_cnt_q;
          wr_rec.waiter   = thread_q;
          wr_rec.deadline = dl_new;
          wr_rec.endpoint = endpoint_q;
          wr_rec.prio     = prio_q;
          wr_rec.determ   = det_q;
          id_cnt_d = id_cnt_q + 32'd1;
          idx_d    = 6'(head);
          rid_d    = id_cnt_q;
          dl_d     = dl_new;
        end
      end else if (!slot_pending) begin
        code_d = ResNotPending;
        idx_d  = sel_q;
      end else begin
        // release: free the slot and push it back on the list
        fl_ctrl.push    = 1'b1;
        st_ctrl.wr      = 1'b1;
        st_wr_idx       = sel_q_cmp[IdxW-1:0];
        wr_rec.busy     = 1'b0;
        wr_rec.status   = new_status;
        wr_rec.waiter   = '0;
        wr_rec.deadline = '0;
        idx_d  = sel_q;
        rid_d  = rd_rec.id;
        fst_d  = new_status;
        wake_d = wk;
        wthr_d = wk ? rd_rec.waiter : '0;
        wpri_d = wk ? rd_rec.prio : '0;
      end
    end
  end

  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      stage_d = 1'b1;
    end else if (done) begin
      stage_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
      id_cnt_q    <= 32'd1;
    end else begin
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
      id_cnt_q    <= id_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      sel_q      <= slot_sel_i;
      thread_q   <= thread_ref_i;
      endpoint_q <= endpoint_ref_i;
      timeout_q  <= timeout_ms_i;
      prio_q     <= qos_priority_i;
      det_q      <= deterministic_i;
      now_q      <= now_ticks_i;
      blocked_q  <= waiter_blocked_i;
    end
    code_q <= code_d;
    idx_q  <= idx_d;
    rid_q  <= rid_d;
    dl_q   <= dl_d;
    fst_q  <= fst_d;
    wake_q <= wake_d;
    wthr_q <= wthr_d;
    wpri_q <= wpri_d;
  end

  arst_free_list #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW)
  ) u_free_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (fl_ctrl),
    .push_idx_i (sel_q_cmp[IdxW-1:0]),
    .head_o     (head),
    .mark_o     (mark)
  );

  arst_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW)
  ) u_slot_table (
    .clk_i    (clk_i),
    .ctrl_i   (st_ctrl),
    .rd_idx_i (sel_in_cmp[IdxW-1:0]),
    .wr_idx_i (st_wr_idx),
    .wr_rec_i (wr_rec),
    .rd_rec_o (rd_rec)
  );

  assign in_stall_o      = stage_q;
  assign out_valid_o     = out_valid_q;
  assign result_code_o   = code_q;
  assign slot_index_o    = idx_q;
  assign request_id_o    = rid_q;
  assign deadline_o      = dl_q;
  assign final_status_o  = fst_q;
  assign wake_o          = wake_q;
  assign wake_thread_o   = wthr_q;
  assign wake_priority_o = wpri_q;

endmodule : async_request_slot_tracker

`default_nettype wire

### hdl/arst_checker.sv
// ----------------------------------------------------------------------------
// arst_checker
// Port-level checks of the request slot tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arst_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  result_code_o,
  input wire [5:0]  slot_index_o,
  input wire [31:0] request_id_o,
  input wire [63:0] deadline_o,
  input wire [1:0]  final_status_o,
  input wire        wake_o
);
  import arst_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_code_o)
      && $stable(slot_index_o) && $stable(request_id_o))
    else $error("stalled result changed");

  // one transaction in flight: accept blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while another is in flight");

  a_not_pending_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o == ResNotPending) |->
      (request_id_o == '0) && (deadline_o == '0) && !wake_o
      && (final_status_o == StPending))
    else $error("rejected release carries data");

  a_wake_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_o |->
      (result_code_o == ResOk) && (final_status_o != StPending)
      && (deadline_o == '0))
    else $error("wakeup outside a successful release");

  a_create_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((result_code_o == ResNoThread) || (result_code_o == ResFull)) |->
      (slot_index_o == '0) && (request_id_o == '0) && !wake_o)
    else $error("failed create carries data");

endmodule : arst_checker

bind async_request_slot_tracker arst_checker u_arst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_code_o  (result_code_o),
  .slot_index_o   (slot_index_o),
  .request_id_o   (request_id_o),
  .deadline_o     (deadline_o),
  .final_status_o (final_status_o),
  .wake_o         (wake_o)
);

`default_nettype wire

### tb/sv/async_request_slot_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_request_slot_tracker_test
// Drives create, complete, cancel and timeout transactions into the slot
// tracker with random idle and stall patterns. A scoreboard keeps its own copy
// of the slot table and free list, predicts each result and checks every
// output transaction field by field, in order.
// ----------------------------------------------------------------------------

module async_request_slot_tracker_test;
  import arst_pkg::*;

  localparam int SLOTS      = 64;
  localparam int CYCLE_MAX  = 600000;
  localparam int ITEM_GOAL  = 1300;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  sel;
    logic [15:0] thread;
    logic [31:0] endpoint;
    logic [63:0] timeout;
    logic [31:0] prio;
    logic        det;
    logic [63:0] now;
    logic        blocked;
  } tracker_op_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [5:0]  idx;
    logic [31:0] id;
    logic [63:0] dl;
    logic [1:0]  st;
    logic        wake;
    logic [15:0] wthread;
    logic [31:0] wprio;
  } tracker_res_t;

  // Mirror of the slot table; predicts one result per accepted transaction.
  class slot_scoreboard;
    logic [6:0]   head;
    logic [6:0]   link[SLOTS];
    bit           busy[SLOTS];
    logic [1:0]   status[SLOTS];
    logic [31:0]  ids[SLOTS];
    logic [15:0]  waiter[SLOTS];
    logic [31:0]  prio[SLOTS];
    logic [31:0]  next_id;
    tracker_res_t expected_q[$];
    int           errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        link[i] = 7'(i + 1);
        busy[i] = 1'b0;
      end
      head    = '0;
      next_id = 32'd1;
      errors  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // random busy slot, or -1 when the table is empty
    function int pick_busy();
      int start;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        if (busy[(start + k) % SLOTS]) return (start + k) % SLOTS;
      end
      return -1;
    endfunction

    function void note_op(tracker_op_t op);
      tracker_res_t r;
      logic [5:0]   s;
      logic [1:0]   st;
      bit           wk;
      r = '0;
      if (op.func == FuncCreate) begin
        if (op.thread == '0) begin
          r.code = ResNoThread;
        end else if (head >= SLOTS) begin
          r.code = ResFull;
        end else begin
          s         = head[5:0];
          head      = link[s];
          busy[s]   = 1'b1;
          status[s] = StPending;
          ids[s]    = next_id;
          next_id   = next_id + 32'd1;
          waiter[s] = op.thread;
          prio[s]   = op.prio;
          r.code    = ResOk;
          r.idx     = s;
          r.id      = ids[s];
          r.dl      = (op.timeout == '0) ? '0 : op.now + op.timeout;
          r.st      = StPending;
        end
      end else begin
        s = op.sel;
        if (!busy[s] || status[s] != StPending) begin
          r.code = ResNotPending;
          r.idx  = s;
        end else begin
          case (op.func)
            FuncComplete: st = StCompleted;
            FuncCancel:   st = StCancelled;
            default:      st = StTimedOut;
          endcase
          wk     = (waiter[s] != '0) && op.blocked;
          r.code = ResOk;
          r.idx  = s;
          r.id   = ids[s];
          r.st   = st;
          r.wake = wk;
          if (wk) begin
            r.wthread = waiter[s];
            r.wprio   = prio[s];
          end
          status[s] = st;
          busy[s]   = 1'b0;
          waiter[s] = '0;
          link[s]   = head;
          head      = {1'b0, s};
        end
      end
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
      end
    endfunction

    function void check_result(tracker_res_t got);
      tracker_res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      cmp_field("result_code", 64'(e.code), 64'(got.code));
      cmp_field("slot_index", 64'(e.idx), 64'(got.idx));
      cmp_field("request_id", 64'(e.id), 64'(got.id));
      cmp_field("deadline", e.dl, got.dl);
      cmp_field("final_status", 64'(e.st), 64'(got.st));
      cmp_field("wake", 64'(e.wake), 64'(got.wake));
      cmp_field("wake_thread", 64'(e.wthread), 64'(got.wthread));
      cmp_field("wake_priority", 64'(e.wprio), 64'(got.wprio));
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic [1:0]  func_i           = '0;
  logic [5:0]  slot_sel_i       = '0;
  logic [15:0] thread_ref_i     = '0;
  logic [31:0] endpoint_ref_i   = '0;
  logic [63:0] timeout_ms_i     = '0;
  logic [31:0] qos_priority_i   = '0;
  logic        deterministic_i  = 1'b0;
  logic [63:0] now_ticks_i      = '0;
  logic        waiter_blocked_i = 1'b0;
  logic        out_stall_i      = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  result_code_o;
  logic [5:0]  slot_index_o;
  logic [31:0] request_id_o;
  logic [63:0] deadline_o;
  logic [1:0]  final_status_o;
  logic        wake_o;
  logic [15:0] wake_thread_o;
  logic [31:0] wake_priority_o;

  slot_scoreboard sb;
  bit             hold_out = 1'b0;
  int             cycle_cnt = 0;

  async_request_slot_tracker #(.SLOT_COUNT(SLOTS)) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .slot_sel_i       (slot_sel_i),
    .thread_ref_i     (thread_ref_i),
    .endpoint_ref_i   (endpoint_ref_i),
    .timeout_ms_i     (timeout_ms_i),
    .qos_priority_i   (qos_priority_i),
    .deterministic_i  (deterministic_i),
    .now_ticks_i      (now_ticks_i),
    .waiter_blocked_i (waiter_blocked_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_code_o    (result_code_o),
    .slot_index_o     (slot_index_o),
    .request_id_o     (request_id_o),
    .deadline_o       (deadline_o),
    .final_status_o   (final_status_o),
    .wake_o           (wake_o),
    .wake_thread_o    (wake_thread_o),
    .wake_priority_o  (wake_priority_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tracker_op_t rand_op(int create_pct);
    tracker_op_t op;
    int          r;
    int          s;
    op.endpoint = $urandom();
    op.prio     = $urandom();
    op.det      = 1'($urandom_range(0, 1));
    op.now      = rand64();
    op.blocked  = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    op.timeout = (r < 2) ? '0 :
                 (r < 3) ? {32'hFFFF_FFFF, $urandom()} :
                 (r < 5) ? 64'($urandom_range(1, 1000)) : rand64();
    op.thread = ($urandom_range(0, 19) == 0) ? '0 : 16'($urandom_range(1, 65535));
    op.sel    = 6'($urandom_range(0, SLOTS - 1));
    if ($urandom_range(0, 99) < create_pct) begin
      op.func = FuncCreate;
    end else begin
      op.func = 2'($urandom_range(1, 3));
      s = sb.pick_busy();
      if (s >= 0 && $urandom_range(0, 99) < 85) op.sel = 6'(s);
    end
    return op;
  endfunction

  task automatic send_op(tracker_op_t op, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= op.func;
    slot_sel_i       <= op.sel;
    thread_ref_i     <= op.thread;
    endpoint_ref_i   <= op.endpoint;
    timeout_ms_i     <= op.timeout;
    qos_priority_i   <= op.prio;
    deterministic_i  <= op.det;
    now_ticks_i      <= op.now;
    waiter_blocked_i <= op.blocked;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_op(op);
  endtask

  task automatic issue(logic [1:0] f, logic [5:0] sel, logic [15:0] thr, logic [31:0] ep,
                       logic [63:0] tmo, logic [31:0] pr, logic det, logic [63:0] now,
                       logic blk, int gap);
    tracker_op_t op;
    op = '{func: f, sel: sel, thread: thr, endpoint: ep, timeout: tmo, prio: pr,
           det: det, now: now, blocked: blk};
    send_op(op, gap);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // receiver side: random stall pattern, plus one long hold on request
  initial begin
    int dur;
    int r;
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        dur = (r < 50) ? $urandom_range(1, 20) :
              (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall_i <= (r >= 50);
        repeat (dur) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{code: result_code_o, idx: slot_index_o, id: request_id_o,
                        dl: deadline_o, st: final_status_o, wake: wake_o,
                        wthread: wake_thread_o, wprio: wake_priority_o});
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_MAX) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    tracker_op_t op;
    int          n_items;
    int          phase;
    int          create_pct;
    bit          no_idle;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: failures, field extremes, deadline wrap, wakeups, LIFO reuse
    issue(FuncCreate, '0, '0, '1, 64'd5, '1, 1'b1, 64'd9, 1'b1, 0);
    issue(FuncCreate, '1, '1, '1, '0, '1, 1'b1, '1, 1'b1, 0);
    issue(FuncCreate, '0, 16'd1, '0, '1, '0, 1'b0, '1, 1'b0, 0);
    issue(FuncCreate, '0, 16'h8000, 32'h8000_0000, 64'd1, 32'd1, 1'b0, '0, 1'b0, 1);
    issue(FuncComplete, 6'd1, '0, '0, '0, '0, 1'b0, '0, 1'b1, 0);
    issue(FuncComplete, 6'd1, '0, '0, '0, '0, 1'b0, '0, 1'b1, 0);
    issue(FuncCancel, 6'd0, '1, '1, '1, '1, 1'b1, '1, 1'b0, 2);
    issue(FuncTimeout, 6'd2, '0, '0, '0, '0, 1'b0, '0, 1'b1, 0);
    issue(FuncTimeout, 6'd63, '1, '1, '1, '1, 1'b1, '1, 1'b1, 0);
    issue(FuncCancel, 6'd63, '0, '0, '0, '0, 1'b0, '0, 1'b0, 0);
    issue(FuncCreate, '0, 16'h00FF, 32'h1234_5678, 64'h8000_0000_0000_0000, 32'hFFFF_0000,
          1'b1, 64'h8000_0000_0000_0000, 1'b0, 0);
    issue(FuncCreate, '0, 16'h7FFF, '0, 64'd100, 32'h0000_FFFF, 1'b0, 64'd200, 1'b0, 0);
    issue(FuncCreate, '0, 16'hFFFE, '1, '0, 32'hA5A5_A5A5, 1'b1, '1, 1'b0, 0);
    issue(FuncCreate, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 0);
    issue(FuncTimeout, 6'd0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 0);
    issue(FuncCancel, 6'd1, '0, '0, '0, '0, 1'b0, '0, 1'b1, 0);
    issue(FuncComplete, 6'd2, '0, '0, '0, '0, 1'b0, '0, 1'b0, 0);
    issue(FuncComplete, 6'd2, '0, '0, '0, '0, 1'b0, '0, 1'b1, 0);
    wait_results_done();

    // random phases, repeated: mostly creates, mixed, mostly releases, random mix
    n_items = 0;
    phase   = 0;
    while (n_items < ITEM_GOAL) begin
      case (phase % 4)
        0:       create_pct = 90;
        1:       create_pct = 50;
        2:       create_pct = 15;
        default: create_pct = $urandom_range(30, 80);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 3) hold_out = 1'b1;
      repeat (100) begin
        op = rand_op(create_pct);
        send_op(op, no_idle ? 0 : idle_gap());
        n_items++;
      end
      if (phase == 2 || phase == 7) wait_results_done();
      phase++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### async_request_slot_tracker.f
hdl/arst_pkg.sv
hdl/arst_free_list.sv
hdl/arst_slot_table.sv
hdl/async_request_slot_tracker.sv
hdl/arst_checker.sv
tb/sv/async_request_slot_tracker_test.sv
